FILE: sv/sm3_pkg.sv
// SM3 compression package: word and state types, constants, round functions.
// Used by sm3_msg_sched, sm3_round and sm3_block_compress_top. No dependencies.
`timescale 1ns / 1ps

package sm3_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_state8;
    typedef logic [15:0][31:0] t_window;

    // Control from the sequencer to the message schedule
    typedef struct packed {
        logic load;    // shift in an incoming message word
        logic expand;  // shift in the next expanded word
    } t_sched_ctl;

    localparam int WINDOW_DEPTH = 16;
    localparam int ROUNDS       = 64;
    localparam int DIGEST_WORDS = 8;

    localparam t_word T_LOW  = 32'h79CC4519;
    localparam t_word T_HIGH = 32'h7A879D8A;

    // Initial value, word A at index 0
    localparam t_state8 IV = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    // Rotate left by a constant amount in 1..31
    function automatic t_word rotl(input t_word x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_word perm_p0(input t_word x);
        perm_p0 = x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic t_word perm_p1(input t_word x);
        perm_p1 = x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

    // Round constant (T_LOW for rounds 0..15, else T_HIGH) rotated by the round index mod 32
    function automatic t_word round_const(input logic [5:0] j);
        logic [63:0] dbl;
        t_word       base;
        base = (j[5:4] == 2'b00) ? T_LOW : T_HIGH;
        dbl  = {base, base} << j[4:0];
        round_const = dbl[63:32];
    endfunction

endpackage

FILE: sv/sm3_msg_sched.sv
// SM3 message schedule: 16-word shift window, filled by input words and
// extended by one expanded word per round. Depends on sm3_pkg.
`timescale 1ns / 1ps

module sm3_msg_sched (
    input  logic                i_clk,
    input  sm3_pkg::t_sched_ctl i_ctl,
    input  sm3_pkg::t_word      i_word,
    output sm3_pkg::t_word      o_w,
    output sm3_pkg::t_word      o_wp
);

    sm3_pkg::t_window r_win;
    sm3_pkg::t_word   w_next;
    sm3_pkg::t_word   w_expand;

    // W[j+16] from the window, where r_win[0] holds W[j]
    assign w_expand = sm3_pkg::perm_p1(r_win[0] ^ r_win[7] ^ sm3_pkg::rotl(r_win[13], 15))
                    ^ sm3_pkg::rotl(r_win[3], 7) ^ r_win[10];

    assign w_next = i_ctl.load ? i_word : w_expand;

    // Shift the window toward index 0
    always_ff @(posedge i_clk) begin
        if (i_ctl.load || i_ctl.expand) begin
            r_win <= {w_next, r_win[sm3_pkg::WINDOW_DEPTH-1:1]};
        end
    end

    assign o_w  = r_win[0];
    assign o_wp = r_win[0] ^ r_win[4];

endmodule

FILE: sv/sm3_round.sv
// SM3 round unit: working registers A..H and the shared round datapath,
// one round per step. Depends on sm3_pkg.
`timescale 1ns / 1ps

module sm3_round (
    input  logic             i_clk,
    input  logic             i_start,
    input  logic             i_step,
    input  logic [5:0]       i_round,
    input  sm3_pkg::t_state8 i_init,
    input  sm3_pkg::t_word   i_w,
    input  sm3_pkg::t_word   i_wp,
    output sm3_pkg::t_state8 o_state
);

    sm3_pkg::t_state8 r_work;
    sm3_pkg::t_state8 n_work;
    sm3_pkg::t_word   a12, ss1, ss2, ff, gg, tt1, tt2;
    logic             early;

    // Round function
    always_comb begin
        early = (i_round[5:4] == 2'b00);
        a12   = sm3_pkg::rotl(r_work[0], 12);
        ss1   = sm3_pkg::rotl(a12 + r_work[4] + sm3_pkg::round_const(i_round), 7);
        ss2   = ss1 ^ a12;
        if (early) begin
            ff = r_work[0] ^ r_work[1] ^ r_work[2];
            gg = r_work[4] ^ r_work[5] ^ r_work[6];
        end else begin
            ff = (r_work[0] & r_work[1]) | (r_work[0] & r_work[2]) | (r_work[1] & r_work[2]);
            gg = (r_work[4] & r_work[5]) | (~r_work[4] & r_work[6]);
        end
        tt1 = ff + r_work[3] + ss2 + i_wp;
        tt2 = gg + r_work[7] + ss1 + i_w;
        n_work[0] = tt1;
        n_work[1] = r_work[0];
        n_work[2] = sm3_pkg::rotl(r_work[1], 9);
        n_work[3] = r_work[2];
        n_work[4] = sm3_pkg::perm_p0(tt2);
        n_work[5] = r_work[4];
        n_work[6] = sm3_pkg::rotl(r_work[5], 19);
        n_work[7] = r_work[6];
    end

    // Load from the chaining value or advance one round
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_init;
        end else if (i_step) begin
            r_work <= n_work;
        end
    end

    assign o_state = r_work;

endmodule

FILE: sv/sm3_block_compress_top.sv
// SM3 block compression top: input gather, round sequencer, chaining value
// and digest output. Depends on sm3_pkg, sm3_msg_sched and sm3_round.
`timescale 1ns / 1ps
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  input   | in        | i_in_valid / o_in_ready | i_message_word, i_new_message
//  output  | out       | o_out_valid/ i_out_ready| o_digest_word, o_word_index, o_last
//
//  Words 1..16 of a block are taken one per cycle while i_in_valid is high.
//  After the 16th word the round unit runs the 64 rounds, one per cycle, then
//  S_FINAL folds the result into the chaining value, and eight digest words
//  follow, one per taken cycle.
//  Input is not ready from the 16th word until the last digest word is taken.
//  Reset loads the initial value and clears the word and round counters.

module sm3_block_compress_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_message_word,
    input  logic        i_new_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last
);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_ROUND = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [3:0]          r_count, n_count;
    logic [5:0]          r_round, n_round;
    logic [2:0]          r_idx, n_idx;
    sm3_pkg::t_state8    r_chain, n_chain;
    sm3_pkg::t_state8    w_work;
    sm3_pkg::t_state8    w_init;
    sm3_pkg::t_word      w_w, w_wp;
    sm3_pkg::t_sched_ctl sched_ctl;
    logic                in_acc, out_acc, block_done, start, step;

    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = o_out_valid && i_out_ready;
    assign block_done = in_acc && !i_new_message && (r_count == 4'd15);
    assign start      = block_done;
    assign step       = (r_state == S_ROUND);
    assign w_init     = r_chain;

    assign sched_ctl.load   = in_acc;
    assign sched_ctl.expand = step;

    sm3_msg_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .i_word (i_message_word),
        .o_w    (w_w),
        .o_wp   (w_wp)
    );

    sm3_round u_round (
        .i_clk   (i_clk),
        .i_start (start),
        .i_step  (step),
        .i_round (r_round),
        .i_init  (w_init),
        .i_w     (w_w),
        .i_wp    (w_wp),
        .o_state (w_work)
    );

    // Sequencer and chaining value
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_round = r_round;
        n_idx   = r_idx;
        n_chain = r_chain;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (i_new_message) begin
                        n_chain = sm3_pkg::IV;
                        n_count = 4'd1;
                    end else if (r_count == 4'd15) begin
                        n_count = 4'd0;
                        n_round = 6'd0;
                        n_state = S_ROUND;
                    end else begin
                        n_count = r_count + 4'd1;
                    end
                end
            end
            S_ROUND: begin
                n_round = r_round + 6'd1;
                if (r_round == 6'(sm3_pkg::ROUNDS - 1)) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                n_chain = r_chain ^ w_work;
                n_idx   = 3'd0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_acc) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'(sm3_pkg::DIGEST_WORDS - 1)) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= 4'd0;
            r_round <= 6'd0;
            r_idx   <= 3'd0;
            r_chain <= sm3_pkg::IV;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_chain <= n_chain;
        end
    end

    // Drive the handshakes and the digest word
    assign o_in_ready    = (r_state == S_LOAD);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_digest_word = r_chain[r_idx];
    assign o_word_index  = r_idx;
    assign o_last        = (r_idx == 3'(sm3_pkg::DIGEST_WORDS - 1));

    // Checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while digest is pending");

    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last) |=> o_in_ready)
        else $error("block did not return to load after last digest word");

    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == 6'(sm3_pkg::ROUNDS - 1)) |=> (r_state == S_FINAL))
        else $error("round sequencer overran");

    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        block_done |=> (r_state == S_ROUND && r_round == 6'd0 && r_count == 4'd0))
        else $error("rounds did not start after sixteenth word");

endmodule
